FILE: hdl/bwm_pkg.sv
// Shared types and constants for the biweight M-scale estimator.
package bwm_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_CONSISTENCY = 4'd0;
  localparam logic [3:0] CFG_TUNING      = 4'd1;
  localparam logic [3:0] CFG_MAX_ITER    = 4'd2;
  localparam logic [3:0] CFG_TOLERANCE   = 4'd3;

  // Register reset values
  localparam logic [31:0] RST_CONSISTENCY = 32'd65536;
  localparam logic [31:0] RST_TUNING      = 32'd101384;
  localparam logic [7:0]  RST_MAX_ITER    = 8'd50;
  localparam logic [31:0] RST_TOLERANCE   = 32'd4295;

  // Result status codes
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO      = 2'd2;

  // Divider and square root sizes
  localparam int DQW        = 81;  // dividend / quotient shift register
  localparam int SQW        = 82;  // square root working width
  localparam int FRAC_STEPS = 32;
  localparam int WIDE_STEPS = 81;
  localparam int SQRT_STEPS = 41;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CUTM, OP_CUTW, OP_SAMP, OP_DIV, OP_RR, OP_DD, OP_D2,
    OP_FSUM, OP_MEAN, OP_QSET, OP_SQSET, OP_SQRT, OP_P0, OP_P1, OP_P2, OP_P3,
    OP_P4, OP_TOL, OP_CONV, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic take;   // sample channel ready
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic sc_zero;
    logic iter_max;
    logic far;
    logic idx_last;
    logic div_last;
    logic sqrt_last;
    logic stop;
    logic out_busy;
  } stat_t;

endpackage

FILE: hdl/bwm_if.sv
// Channel interfaces: samples in, results out, configuration writes.
interface bwm_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] residual;
  logic        [31:0] initial_scale;
  logic               last;
  modport source (output valid, residual, initial_scale, last, input ready);
  modport sink   (input valid, residual, initial_scale, last, output ready);
endinterface

interface bwm_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] scale;
  logic [7:0]  iterations;
  logic [1:0]  status;
  modport source (output valid, scale, iterations, status, input ready);
  modport sink   (input valid, scale, iterations, status, output ready);
endinterface

interface bwm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/biweight_m_scale_estimator.sv
// Top level of the biweight M-scale estimator.
//
//  channel  | role   | beat carries
//  ---------+--------+----------------------------------------------
//  samples  | sink   | residual, initial_scale, last
//  result   | source | scale, iterations, status
//  cfg      | sink   | index, data (always ready)
//
// Samples load one per cycle. After the last beat each iteration runs the
// bit-serial divider for each sample inside the cutoff (32 steps) and twice
// more for the mean and the scale quotient (81 steps each), then the 41-step
// square root; samples beyond the cutoff skip the divider. The samples
// channel is stalled meanwhile. A finished result waits in the output
// register while new samples load. Reset (rst, synchronous) empties the
// store count and restores the register defaults; no clearing pass runs.
module biweight_m_scale_estimator #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  bwm_sample_if.sink   samples,
  bwm_result_if.source result,
  bwm_cfg_if.sink      cfg
);
  import bwm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bwm_controller u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  bwm_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .samples (samples),
    .result  (result),
    .cfg     (cfg)
  );

endmodule

FILE: hdl/bwm_datapath.sv
// Datapath: sample memory, shared multiplier, divider, square root, registers.
module bwm_datapath #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  bwm_pkg::cmd_t   cmd,
  output bwm_pkg::stat_t  stat,
  bwm_sample_if.sink      samples,
  bwm_result_if.source    result,
  bwm_cfg_if.sink         cfg
);
  import bwm_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // Configuration registers
  logic [31:0] consistency, tuning, tol;
  logic [7:0]  max_iter;

  // Sample store
  logic [31:0]   mem [MAX_SAMPLES];
  logic [31:0]   rdata;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic          wr_en;

  // Iteration state
  logic [31:0]  sc, nsc;
  logic [7:0]   iter;
  logic         conv;
  logic [63:0]  cut, acc, mul_p;
  logic [31:0]  d, d2;
  logic [104:0] prod;

  // Divider and square root
  logic [63:0]     drem, dd;
  logic [DQW-1:0]  dqd;
  logic [6:0]      dcnt;
  logic [SQW-1:0]  sop, sres, sone;
  logic [5:0]      scnt;

  // Output register
  logic        out_valid;
  logic [31:0] out_scale;
  logic [7:0]  out_iter;
  logic [1:0]  out_status;

  // Combinational helpers
  logic [31:0]    mag, mul_a, mul_b, kp, s_lo, s_hi;
  logic [47:0]    a_val;
  logic           mul_en;
  logic [64:0]    rem2, rem_n;
  logic           ge;
  logic [SQW-1:0] sq_t;
  logic           sge;
  logic [34:0]    fsum, k6;
  logic [32:0]    fcl, m_val;
  logic [31:0]    diff;
  logic           conv_now;

  assign samples.ready = cmd.take;
  assign cfg.ready     = 1'b1;
  assign result.valid      = out_valid;
  assign result.scale      = out_scale;
  assign result.iterations = out_iter;
  assign result.status     = out_status;

  assign wr_en = (cmd.op == OP_LOAD) && (count != CW'(MAX_SAMPLES));

  // Sample magnitude, divider and root steps, rho polynomial
  always_comb begin
    mag   = rdata[31] ? (~rdata + 32'd1) : rdata;
    a_val = {mag, 16'd0};
    rem2  = {drem, dqd[DQW-1]};
    ge    = rem2 >= {1'b0, dd};
    rem_n = ge ? (rem2 - {1'b0, dd}) : rem2;
    sq_t  = sres + sone;
    sge   = sop >= sq_t;
    fsum  = {3'd0, d} + {2'd0, d, 1'b0} - ({3'd0, d2} + {2'd0, d2, 1'b0})
            + {3'd0, mul_p[63:32]};
    fcl   = (fsum > 35'h1_0000_0000) ? 33'h1_0000_0000 : fsum[32:0];
    m_val = dqd[32:0];
    kp    = (consistency == 32'd0) ? 32'd1 : consistency;
    k6    = {1'b0, kp, 2'd0} + {2'd0, kp, 1'b0};
    s_lo  = sres[31:0];
    s_hi  = {23'd0, sres[40:32]};
    diff  = (nsc > sc) ? (nsc - sc) : (sc - nsc);
    conv_now = {diff, 32'd0} <= mul_p;
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.op)
      OP_CUTM: begin mul_a = sc;           mul_b = tuning;       end
      OP_RR:   begin mul_a = dqd[31:0];    mul_b = dqd[31:0];    end
      OP_DD:   begin mul_a = mul_p[63:32]; mul_b = mul_p[63:32]; end
      OP_D2:   begin mul_a = mul_p[63:32]; mul_b = d;            end
      OP_P0:   begin mul_a = cut[31:0];    mul_b = s_lo;         end
      OP_P1:   begin mul_a = cut[31:0];    mul_b = s_hi;         end
      OP_P2:   begin mul_a = cut[63:32];   mul_b = s_lo;         end
      OP_P3:   begin mul_a = cut[63:32];   mul_b = s_hi;         end
      OP_TOL:  begin mul_a = tol;          mul_b = sc;           end
      default: mul_en = 1'b0;
    endcase
  end

  // Store samples, read the addressed sample
  always_ff @(posedge clk) begin
    if (wr_en) mem[count[AW-1:0]] <= samples.residual;
    rdata <= mem[idx];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      consistency <= RST_CONSISTENCY;
      tuning      <= RST_TUNING;
      max_iter    <= RST_MAX_ITER;
      tol         <= RST_TOLERANCE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CONSISTENCY: consistency <= cfg.data;
        CFG_TUNING:      tuning      <= cfg.data;
        CFG_MAX_ITER:    max_iter    <= cfg.data[7:0];
        CFG_TOLERANCE:   tol         <= cfg.data;
        default: ;
      endcase
    end
  end

  // Control registers: fill count, output beat, scale, iteration count, convergence
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      iter      <= '0;
      sc        <= '0;
      conv      <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          if (wr_en) count <= count + CW'(1);
          if (samples.last) begin
            sc   <= samples.initial_scale;
            iter <= '0;
            conv <= 1'b0;
          end
        end
        OP_CONV: begin
          conv <= conv_now;
          sc   <= nsc;
          iter <= iter + 8'd1;
        end
        OP_EMIT: begin
          count <= '0;
        end
        default: ;
      endcase
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    if (mul_en) mul_p <= mul_a * mul_b;
    unique case (cmd.op)
      OP_CUTW: begin
        cut <= mul_p;
        acc <= '0;
        idx <= '0;
      end
      OP_SAMP: begin
        if (stat.far) begin
          acc <= acc + 64'h1_0000_0000;
          if (!stat.idx_last) idx <= idx + AW'(1);
        end else begin
          drem <= {16'd0, a_val};
          dqd  <= '0;
          dd   <= cut;
          dcnt <= 7'(FRAC_STEPS);
        end
      end
      OP_DIV: begin
        drem <= rem_n[63:0];
        dqd  <= {dqd[DQW-2:0], ge};
        dcnt <= dcnt - 7'd1;
      end
      OP_DD: d  <= mul_p[63:32];
      OP_D2: d2 <= mul_p[63:32];
      OP_FSUM: begin
        acc <= acc + {31'd0, fcl};
        if (!stat.idx_last) idx <= idx + AW'(1);
      end
      OP_MEAN: begin
        drem <= '0;
        dqd  <= {17'd0, acc};
        dd   <= 64'(count);
        dcnt <= 7'(WIDE_STEPS);
      end
      OP_QSET: begin
        drem <= '0;
        dqd  <= {m_val, 48'd0};
        dd   <= {29'd0, k6};
        dcnt <= 7'(WIDE_STEPS);
      end
      OP_SQSET: begin
        sop  <= {1'b0, dqd};
        sres <= '0;
        sone <= SQW'(1) << (2 * (SQRT_STEPS - 1));
        scnt <= 6'(SQRT_STEPS);
      end
      OP_SQRT: begin
        sop  <= sge ? (sop - sq_t) : sop;
        sres <= sge ? ((sres >> 1) + sone) : (sres >> 1);
        sone <= sone >> 2;
        scnt <= scnt - 6'd1;
      end
      OP_P1: prod <= {41'd0, mul_p};
      OP_P2: prod <= prod + {9'd0, mul_p, 32'd0};
      OP_P3: prod <= prod + {9'd0, mul_p, 32'd0};
      OP_P4: prod <= prod + {mul_p[40:0], 64'd0};
      OP_TOL: nsc <= (prod[104:80] != '0) ? 32'hFFFF_FFFF : prod[79:48];
      OP_EMIT: begin
        out_scale  <= sc;
        out_iter   <= iter;
        out_status <= (sc == 32'd0) ? ST_ZERO : (conv ? ST_CONVERGED : ST_LIMIT);
      end
      default: ;
    endcase
  end

  // Status back to the controller
  always_comb begin
    stat.in_valid  = samples.valid;
    stat.in_last   = samples.last;
    stat.sc_zero   = sc == 32'd0;
    stat.iter_max  = iter >= max_iter;
    stat.far       = {16'd0, a_val} >= cut;
    stat.idx_last  = CW'(idx) == (count - CW'(1));
    stat.div_last  = dcnt == 7'd1;
    stat.sqrt_last = scnt == 6'd1;
    stat.stop      = conv_now || (nsc == 32'd0);
    stat.out_busy  = out_valid && !result.ready;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES)) else $error("fill count beyond store depth");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |=> out_valid) else $error("emitted result not shown");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status != 2'd3) else $error("bad status code");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIV |-> dcnt != 7'd0) else $error("divider stepped past end");

endmodule

FILE: hdl/bwm_controller.sv
// Controller: sequences loading, each iteration's passes and the result beat.
module bwm_controller (
  input  logic           clk,
  input  logic           rst,
  input  bwm_pkg::stat_t stat,
  output bwm_pkg::cmd_t  cmd
);
  import bwm_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE  = 25'h0000001, S_CHECK = 25'h0000002, S_CUTM  = 25'h0000004,
    S_CUTW  = 25'h0000008, S_RD    = 25'h0000010, S_SAMP  = 25'h0000020,
    S_DIV   = 25'h0000040, S_RR    = 25'h0000080, S_DD    = 25'h0000100,
    S_D2    = 25'h0000200, S_FSUM  = 25'h0000400, S_MEAN  = 25'h0000800,
    S_MDIV  = 25'h0001000, S_QSET  = 25'h0002000, S_QDIV  = 25'h0004000,
    S_SQSET = 25'h0008000, S_SQRT  = 25'h0010000, S_P0    = 25'h0020000,
    S_P1    = 25'h0040000, S_P2    = 25'h0080000, S_P3    = 25'h0100000,
    S_P4    = 25'h0200000, S_TOL   = 25'h0400000, S_CONV  = 25'h0800000,
    S_DONE  = 25'h1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.take   = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid) begin
          cmd.op = OP_LOAD;
          if (stat.in_last) state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = (stat.iter_max || stat.sc_zero) ? S_DONE : S_CUTM;
      S_CUTM: begin cmd.op = OP_CUTM; state_next = S_CUTW; end
      S_CUTW: begin cmd.op = OP_CUTW; state_next = S_RD; end
      S_RD:   state_next = S_SAMP;
      S_SAMP: begin
        cmd.op = OP_SAMP;
        if (!stat.far)         state_next = S_DIV;
        else if (stat.idx_last) state_next = S_MEAN;
        else                    state_next = S_RD;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_next = S_RR;
      end
      S_RR: begin cmd.op = OP_RR; state_next = S_DD; end
      S_DD: begin cmd.op = OP_DD; state_next = S_D2; end
      S_D2: begin cmd.op = OP_D2; state_next = S_FSUM; end
      S_FSUM: begin
        cmd.op     = OP_FSUM;
        state_next = stat.idx_last ? S_MEAN : S_RD;
      end
      S_MEAN: begin cmd.op = OP_MEAN; state_next = S_MDIV; end
      S_MDIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_next = S_QSET;
      end
      S_QSET: begin cmd.op = OP_QSET; state_next = S_QDIV; end
      S_QDIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_next = S_SQSET;
      end
      S_SQSET: begin cmd.op = OP_SQSET; state_next = S_SQRT; end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (stat.sqrt_last) state_next = S_P0;
      end
      S_P0:  begin cmd.op = OP_P0;  state_next = S_P1; end
      S_P1:  begin cmd.op = OP_P1;  state_next = S_P2; end
      S_P2:  begin cmd.op = OP_P2;  state_next = S_P3; end
      S_P3:  begin cmd.op = OP_P3;  state_next = S_P4; end
      S_P4:  begin cmd.op = OP_P4;  state_next = S_TOL; end
      S_TOL: begin cmd.op = OP_TOL; state_next = S_CONV; end
      S_CONV: begin
        cmd.op     = OP_CONV;
        state_next = stat.stop ? S_DONE : S_CHECK;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
